// ===== rtl/sbca_pkg.sv =====
`default_nettype none

package sbca_pkg;

  localparam int unsigned BEAM_W = 16;
  localparam int unsigned SLOT_W = 5;

  typedef logic signed [BEAM_W-1:0] beam_t;

  typedef struct packed {
    beam_t depth;
    beam_t distance;
  } beam_pair_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TRY3,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/sbca_mem.sv =====
`default_nettype none

module sbca_mem import sbca_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic       clk_i,
  input  wire logic       wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire beam_pair_t wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output beam_pair_t      rd_data_o
);

  beam_pair_t mem_q [DEPTH];
  beam_pair_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== rtl/sbca_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module sbca_div #(
  parameter int unsigned NW = 23,
  parameter int unsigned DW = 18
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   sh;
  logic [DW:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    sh     = {rem_q, quo_q[NW-1]};
    diff   = sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, dvs_q}) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = sh[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/sonar_beam_center_align_top.sv =====
`default_nettype none

// channel | handshake              | payload
// in      | in_valid_i / in_stall_o | beam_depth_i, beam_distance_i, last_beam_i
// out     | out_valid_o / out_stall_i | slot_index_o, slot_depth_o, slot_distance_o,
//         |                        | center_found_o, last_slot_o
//
// a beam that is not last is written to the beam ram if fewer than RAW_BEAMS are stored
// on the last beam: one scan of the beam ram, then up to two interpolations
// of a multiply and a divide each (divider width is $clog2(RAW_BEAMS)+19),
// then a read and a load per output slot, the load held by any output stall
// in_stall_o is high from the last beam until the final slot is loaded
// reset clears the control state only; the beam ram holds no reset value
module sonar_beam_center_align_top import sbca_pkg::*; #(
  parameter int unsigned RAW_BEAMS  = 16,
  parameter int unsigned PROC_BEAMS = 19,
  parameter int unsigned OUT_BEAMS  = 19
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [BEAM_W-1:0] beam_depth_i,
  input  wire logic [BEAM_W-1:0] beam_distance_i,
  input  wire logic              last_beam_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [SLOT_W-1:0]      slot_index_o,
  output logic [BEAM_W-1:0]      slot_depth_o,
  output logic [BEAM_W-1:0]      slot_distance_o,
  output logic                   center_found_o,
  output logic                   last_slot_o
);

  localparam int unsigned IDXW = $clog2(RAW_BEAMS);
  localparam int unsigned CNTW = $clog2(RAW_BEAMS + 1);
  localparam int unsigned SCW  = $clog2(RAW_BEAMS + 2);
  localparam int unsigned SW   = $clog2(OUT_BEAMS);
  localparam int unsigned DIFW = IDXW + 1;
  localparam int unsigned PW   = DIFW + BEAM_W + 1;
  localparam int unsigned N2W  = PW + 2;
  localparam int unsigned MAGW = N2W - 1;
  localparam int unsigned DENW = BEAM_W + 1;
  localparam int unsigned DVW  = DENW + 1;
  localparam int unsigned CW   = N2W + 1;
  localparam int unsigned EW   = $clog2(OUT_BEAMS + PROC_BEAMS + RAW_BEAMS) + 2;
  localparam int KOFF  = int'(OUT_BEAMS) - 1 - int'(PROC_BEAMS / 2);
  localparam int HALF  = int'(PROC_BEAMS / 2);
  localparam int UPPER = int'(PROC_BEAMS) - int'(PROC_BEAMS / 2);

  state_e state_q, state_d;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] ldn_q, ldn_d;
  logic [SCW-1:0]  sc_q, sc_d;

  beam_t p_dist_q, p_dist_d, p_depth_q, p_depth_d, pp_dist_q, pp_dist_d;

  logic            f1_q, f1_d;
  logic [IDXW-1:0] c1_q, c1_d;
  beam_t           jpos2_q, jpos2_d, jneg2_q, jneg2_d;
  logic [IDXW-1:0] ipos2_q, ipos2_d, ineg2_q, ineg2_d;
  logic            any3_q, any3_d;
  beam_t           jpos3_q, jpos3_d, jneg3_q, jneg3_d;
  logic [IDXW-1:0] ipos3_q, ipos3_d, ineg3_q, ineg3_d;
  logic            pass3_q, pass3_d;

  logic [IDXW-1:0]       op_ineg_q, op_ineg_d, op_ipos_q, op_ipos_d;
  beam_t                 op_dneg_q, op_dneg_d, op_dpos_q, op_dpos_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic [DENW-1:0]       den_q, den_d;
  logic                  neg_q, neg_d;

  logic [IDXW-1:0] ctr_q, ctr_d;
  logic            found_q, found_d;
  logic [SW-1:0]   slot_q, slot_d;
  logic            sel_ok_q, sel_ok_d;

  logic            out_vld_q, out_vld_d;
  logic [SW-1:0]   oslot_q, oslot_d;
  beam_t           odepth_q, odepth_d, odist_q, odist_d;
  logic            ofound_q, ofound_d, olast_q, olast_d;

  // ram port signals
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  beam_pair_t      wr_data;
  logic [IDXW-1:0] rd_addr;
  beam_pair_t      rd_data;

  // scan datapath
  logic            cur_ok;
  beam_t           cur_dist, cur_depth;
  logic [SCW-1:0]  cur_pos, jpos_scan;
  logic [IDXW-1:0] cur_idx;

  // interpolation datapath
  logic signed [DIFW-1:0]   diff_s;
  logic signed [BEAM_W:0]   negd_s;
  logic [DENW-1:0]          den_w;
  logic [N2W-1:0]           num2;
  logic [MAGW-1:0]          mag;
  logic                     div_start, div_done;
  logic [MAGW-1:0]          quot;
  logic signed [CW-1:0]     tq, cc;

  // slot placement
  logic signed [EW-1:0] ei, ctr_s;
  logic                 sel;
  logic                 acc_in;
  logic                 out_load;

  sbca_mem #(
    .DEPTH (RAW_BEAMS),
    .AW    (IDXW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sbca_div #(
    .NW (MAGW),
    .DW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  ({den_q, 1'b0}),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign acc_in  = in_valid_i && (state_q == ST_IDLE);
  assign wr_en   = acc_in && (cnt_q < CNTW'(RAW_BEAMS));
  assign wr_addr = cnt_q[IDXW-1:0];
  assign wr_data = '{depth: beam_t'(beam_depth_i), distance: beam_t'(beam_distance_i)};

  // entries past the loaded count read as zero
  assign cur_pos   = sc_q - SCW'(1);
  assign jpos_scan = sc_q - SCW'(2);
  assign cur_idx   = cur_pos[IDXW-1:0];
  assign cur_ok    = (sc_q != '0) && (cur_pos < SCW'(ldn_q));
  assign cur_dist  = cur_ok ? rd_data.distance : '0;
  assign cur_depth = cur_ok ? rd_data.depth : '0;

  assign diff_s = $signed({1'b0, op_ipos_q}) - $signed({1'b0, op_ineg_q});
  assign negd_s = -$signed({op_dneg_q[BEAM_W-1], op_dneg_q});
  assign den_w  = {op_dpos_q[BEAM_W-1], op_dpos_q} - {op_dneg_q[BEAM_W-1], op_dneg_q};
  assign num2   = {prod_q[PW-1], prod_q, 1'b0} + {{(N2W-DENW){1'b0}}, den_q};
  assign mag    = num2[N2W-1] ? MAGW'(~num2 + N2W'(1)) : MAGW'(num2);
  assign tq     = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign cc     = tq + $signed({{(CW-IDXW){1'b0}}, op_ineg_q});

  assign ctr_s = $signed({{(EW-IDXW){1'b0}}, ctr_q});
  assign ei    = $signed(EW'(KOFF)) + ctr_s - $signed({{(EW-SW){1'b0}}, slot_q});
  assign sel   = found_q && (ei >= 0) && (ei < $signed(EW'(RAW_BEAMS)))
              && (ei >= ctr_s - $signed(EW'(HALF)))
              && (ei < ctr_s + $signed(EW'(UPPER)))
              && (ei < $signed({{(EW-CNTW){1'b0}}, ldn_q}));

  assign rd_addr  = (state_q == ST_SCAN) ? sc_q[IDXW-1:0] : ei[IDXW-1:0];
  assign out_load = (state_q == ST_EMIT_LD) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ldn_d     = ldn_q;
    sc_d      = sc_q;
    p_dist_d  = p_dist_q;
    p_depth_d = p_depth_q;
    pp_dist_d = pp_dist_q;
    f1_d      = f1_q;
    c1_d      = c1_q;
    jpos2_d   = jpos2_q;
    jneg2_d   = jneg2_q;
    ipos2_d   = ipos2_q;
    ineg2_d   = ineg2_q;
    any3_d    = any3_q;
    jpos3_d   = jpos3_q;
    jneg3_d   = jneg3_q;
    ipos3_d   = ipos3_q;
    ineg3_d   = ineg3_q;
    pass3_d   = pass3_q;
    op_ineg_d = op_ineg_q;
    op_ipos_d = op_ipos_q;
    op_dneg_d = op_dneg_q;
    op_dpos_d = op_dpos_q;
    prod_d    = prod_q;
    den_d     = den_q;
    neg_d     = neg_q;
    ctr_d     = ctr_q;
    found_d   = found_q;
    slot_d    = slot_q;
    sel_ok_d  = sel_ok_q;
    div_start = 1'b0;
    out_vld_d = out_vld_q && out_stall_i;
    oslot_d   = oslot_q;
    odepth_d  = odepth_q;
    odist_d   = odist_q;
    ofound_d  = ofound_q;
    olast_d   = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          if (cnt_q < CNTW'(RAW_BEAMS)) begin
            cnt_d = cnt_q + CNTW'(1);
          end
          if (last_beam_i) begin
            ldn_d   = (cnt_q < CNTW'(RAW_BEAMS)) ? cnt_q + CNTW'(1) : cnt_q;
            cnt_d   = '0;
            sc_d    = '0;
            f1_d    = 1'b0;
            jpos2_d = '0;
            jneg2_d = '0;
            any3_d  = 1'b0;
            pass3_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        sc_d      = sc_q + SCW'(1);
        p_dist_d  = cur_dist;
        p_depth_d = cur_depth;
        pp_dist_d = p_dist_q;
        // centre test runs one entry behind so the right neighbour is at hand
        if (sc_q >= SCW'(2)) begin
          if (p_dist_q == '0 && p_depth_q != '0) begin
            f1_d = 1'b1;
            c1_d = jpos_scan[IDXW-1:0];
          end else if (!f1_q && p_dist_q == '0 && jpos_scan != '0
                       && jpos_scan < SCW'(RAW_BEAMS - 1)
                       && pp_dist_q < 0 && cur_dist > 0) begin
            f1_d = 1'b1;
            c1_d = jpos_scan[IDXW-1:0];
          end
        end
        if (cur_dist > 0 && (cur_dist < jpos2_q || jpos2_q == '0)) begin
          jpos2_d = cur_dist;
          ipos2_d = cur_idx;
        end
        if (cur_dist < 0 && (cur_dist > jneg2_q || jneg2_q == '0)) begin
          jneg2_d = cur_dist;
          ineg2_d = cur_idx;
        end
        if (cur_dist != '0) begin
          if (!any3_q) begin
            any3_d  = 1'b1;
            jneg3_d = cur_dist;
            ineg3_d = cur_idx;
            jpos3_d = cur_dist;
            ipos3_d = cur_idx;
          end else if (cur_dist < jneg3_q) begin
            jneg3_d = cur_dist;
            ineg3_d = cur_idx;
          end else if (cur_dist > jpos3_q) begin
            jpos3_d = cur_dist;
            ipos3_d = cur_idx;
          end
        end
        if (sc_q == SCW'(RAW_BEAMS + 1)) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (f1_q) begin
          ctr_d   = c1_q;
          found_d = 1'b1;
          slot_d  = '0;
          state_d = ST_EMIT_RD;
        end else if (jpos2_q > 0 && jneg2_q < 0) begin
          op_ineg_d = ineg2_q;
          op_ipos_d = ipos2_q;
          op_dneg_d = jneg2_q;
          op_dpos_d = jpos2_q;
          pass3_d   = 1'b0;
          state_d   = ST_MUL;
        end else begin
          state_d = ST_TRY3;
        end
      end

      ST_TRY3: begin
        if (any3_q && jpos3_q != jneg3_q) begin
          op_ineg_d = ineg3_q;
          op_ipos_d = ipos3_q;
          op_dneg_d = jneg3_q;
          op_dpos_d = jpos3_q;
          pass3_d   = 1'b1;
          state_d   = ST_MUL;
        end else begin
          found_d = 1'b0;
          slot_d  = '0;
          state_d = ST_EMIT_RD;
        end
      end

      ST_MUL: begin
        prod_d  = diff_s * negd_s;
        den_d   = den_w;
        state_d = ST_DIV_GO;
      end

      ST_DIV_GO: begin
        // divide |2*num + den| by 2*den, sign restored afterwards
        neg_d     = num2[N2W-1];
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!cc[CW-1] && cc < $signed(CW'(RAW_BEAMS))) begin
          ctr_d   = cc[IDXW-1:0];
          found_d = 1'b1;
          slot_d  = '0;
          state_d = ST_EMIT_RD;
        end else if (!pass3_q) begin
          state_d = ST_TRY3;
        end else begin
          found_d = 1'b0;
          slot_d  = '0;
          state_d = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        sel_ok_d = sel;
        state_d  = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          oslot_d   = slot_q;
          odepth_d  = sel_ok_q ? rd_data.depth : '0;
          odist_d   = sel_ok_q ? rd_data.distance : '0;
          ofound_d  = found_q;
          olast_d   = (slot_q == SW'(OUT_BEAMS - 1));
          if (slot_q == SW'(OUT_BEAMS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            slot_d  = slot_q + SW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ldn_q     <= '0;
      sc_q      <= '0;
      f1_q      <= 1'b0;
      any3_q    <= 1'b0;
      pass3_q   <= 1'b0;
      found_q   <= 1'b0;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ldn_q     <= ldn_d;
      sc_q      <= sc_d;
      f1_q      <= f1_d;
      any3_q    <= any3_d;
      pass3_q   <= pass3_d;
      found_q   <= found_d;
      slot_q    <= slot_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_dist_q  <= p_dist_d;
    p_depth_q <= p_depth_d;
    pp_dist_q <= pp_dist_d;
    c1_q      <= c1_d;
    jpos2_q   <= jpos2_d;
    jneg2_q   <= jneg2_d;
    ipos2_q   <= ipos2_d;
    ineg2_q   <= ineg2_d;
    jpos3_q   <= jpos3_d;
    jneg3_q   <= jneg3_d;
    ipos3_q   <= ipos3_d;
    ineg3_q   <= ineg3_d;
    op_ineg_q <= op_ineg_d;
    op_ipos_q <= op_ipos_d;
    op_dneg_q <= op_dneg_d;
    op_dpos_q <= op_dpos_d;
    prod_q    <= prod_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    ctr_q     <= ctr_d;
    sel_ok_q  <= sel_ok_d;
    oslot_q   <= oslot_d;
    odepth_q  <= odepth_d;
    odist_q   <= odist_d;
    ofound_q  <= ofound_d;
    olast_q   <= olast_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_vld_q;
  assign slot_index_o    = SLOT_W'(oslot_q);
  assign slot_depth_o    = odepth_q;
  assign slot_distance_o = odist_q;
  assign center_found_o  = ofound_q;
  assign last_slot_o     = olast_q;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
  import sbca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_BEAMS  = 16;
  localparam int PROC_BEAMS = 19;
  localparam int OUT_BEAMS  = 19;
  localparam int BEAM_TARGET = 460;
  localparam int QUIET_TAIL  = 50;
  localparam int STUCK_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    beam_t depth;
    beam_t distance;
    logic  last;
    logic  drain;
  } raw_beam_t;

  typedef struct {
    logic [SLOT_W-1:0] num;
    beam_t             depth;
    beam_t             distance;
    logic              found;
    logic              last;
  } slot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [BEAM_W-1:0] beam_depth_i = '0;
  logic [BEAM_W-1:0] beam_distance_i = '0;
  logic last_beam_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SLOT_W-1:0] slot_index_o;
  logic [BEAM_W-1:0] slot_depth_o;
  logic [BEAM_W-1:0] slot_distance_o;
  logic center_found_o;
  logic last_slot_o;

  raw_beam_t beam_queue[$];
  slot_t     slot_expect[$];

  // predictor state: the ping being loaded and the last centre
  beam_t ping_depth[RAW_BEAMS];
  beam_t ping_dist[RAW_BEAMS];
  int    ping_count = 0;
  int    ping_center = -1;

  int   errors = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   stuck_cycles = 0;
  logic beam_taken = 1'b0;

  sonar_beam_center_align_top #(
    .RAW_BEAMS (RAW_BEAMS),
    .PROC_BEAMS(PROC_BEAMS),
    .OUT_BEAMS (OUT_BEAMS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .beam_depth_i   (beam_depth_i),
    .beam_distance_i(beam_distance_i),
    .last_beam_i    (last_beam_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_index_o   (slot_index_o),
    .slot_depth_o   (slot_depth_o),
    .slot_distance_o(slot_distance_o),
    .center_found_o (center_found_o),
    .last_slot_o    (last_slot_o)
  );

  always #5 clk_i = ~clk_i;

  // rounded crossing point: ineg + trunc(q + 0.5)
  function automatic int interp_center(int ineg, int ipos, int dneg, int dpos);
    longint num;
    longint den;
    longint t;
    num = longint'(ipos - ineg) * longint'(-dneg);
    den = longint'(dpos) - longint'(dneg);
    if (den <= 0) return -1;
    t = (2 * num + den) / (2 * den);
    return ineg + int'(t);
  endfunction

  function automatic int locate_center();
    int c;
    int ipos;
    int ineg;
    int jpos;
    int jneg;
    int d;
    bit any;
    c = -1;
    ipos = 0;
    ineg = 0;
    jpos = 0;
    jneg = 0;
    any = 1'b0;
    for (int i = 0; i < RAW_BEAMS; i++) begin
      d = ping_dist[i];
      if (d == 0 && ping_depth[i] != 0) c = i;
      // neighbour rule is off at both edges of the array
      if (c < 0 && d == 0 && i > 0 && i < RAW_BEAMS - 1) begin
        if (ping_dist[i-1] < 0 && ping_dist[i+1] > 0) c = i;
      end
    end
    if (c < 0) begin
      for (int i = 0; i < RAW_BEAMS; i++) begin
        d = ping_dist[i];
        if (d > 0 && (d < jpos || jpos == 0)) begin
          jpos = d;
          ipos = i;
        end
        if (d < 0 && (d > jneg || jneg == 0)) begin
          jneg = d;
          ineg = i;
        end
      end
      if (jpos > 0 && jneg < 0) c = interp_center(ineg, ipos, jneg, jpos);
      if (c < 0 || c >= RAW_BEAMS) c = -1;
    end
    if (c < 0) begin
      jpos = 0;
      jneg = 0;
      for (int i = 0; i < RAW_BEAMS; i++) begin
        d = ping_dist[i];
        if (d != 0) begin
          if (!any) begin
            any = 1'b1;
            jneg = d;
            ineg = i;
            jpos = d;
            ipos = i;
          end else if (d < jneg) begin
            jneg = d;
            ineg = i;
          end else if (d > jpos) begin
            jpos = d;
            ipos = i;
          end
        end
      end
      if (any && jpos != jneg) c = interp_center(ineg, ipos, jneg, jpos);
      if (c < 0 || c >= RAW_BEAMS) c = -1;
    end
    return c;
  endfunction

  task automatic take_beam(beam_t dep, beam_t dis, logic last);
    beam_t sd[OUT_BEAMS];
    beam_t sx[OUT_BEAMS];
    int id;
    int j;
    int k;
    int l;
    slot_t s;
    if (ping_count < RAW_BEAMS) begin
      ping_depth[ping_count] = dep;
      ping_dist[ping_count] = dis;
      ping_count++;
    end
    if (!last) return;
    for (int i = ping_count; i < RAW_BEAMS; i++) begin
      ping_depth[i] = '0;
      ping_dist[i] = '0;
    end
    ping_count = 0;
    ping_center = locate_center();
    for (int n = 0; n < OUT_BEAMS; n++) begin
      sd[n] = '0;
      sx[n] = '0;
    end
    if (ping_center >= 0) begin
      id = PROC_BEAMS / 2 - ping_center;
      j = (id < 0) ? -id : 0;
      k = (id > PROC_BEAMS - RAW_BEAMS) ? PROC_BEAMS - id : RAW_BEAMS;
      // reversed into the slots, centre beam lands mid-swath
      for (int i = j; i < k; i++) begin
        l = OUT_BEAMS - 1 - id - i;
        if (i >= 0 && i < RAW_BEAMS && l >= 0 && l < OUT_BEAMS) begin
          sd[l] = ping_depth[i];
          sx[l] = ping_dist[i];
        end
      end
    end
    for (int n = 0; n < OUT_BEAMS; n++) begin
      s.num = n[SLOT_W-1:0];
      s.depth = sd[n];
      s.distance = sx[n];
      s.found = (ping_center >= 0);
      s.last = (n == OUT_BEAMS - 1);
      slot_expect.push_back(s);
    end
  endtask

  task automatic add_beam(int dep, int dis, logic last);
    raw_beam_t b;
    b.depth = dep[BEAM_W-1:0];
    b.distance = dis[BEAM_W-1:0];
    b.last = last;
    b.drain = 1'b0;
    beam_queue.push_back(b);
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_depth();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return -int'($urandom_range(1, 32768));
      default: return int'($urandom_range(1, 32767));
    endcase
  endfunction

  // distances fall or rise linearly across the swath with a crossing near p4/4
  task automatic add_swath_ping(int n);
    int p4;
    int s;
    int dir;
    int d;
    p4 = int'($urandom_range(0, 4 * n + 16)) - 8;
    s = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 30000))
                                    : int'($urandom_range(1, 3000));
    dir = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < n; i++) begin
      d = dir * (p4 - 4 * i) * s / 4;
      if ($urandom_range(0, 3) == 0) d += int'($urandom_range(0, 6)) - 3;
      add_beam(pick_depth(), clamp16(d), i == n - 1);
    end
  endtask

  function automatic int noise_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32767;
      2: return -32768;
      3: return -1;
      4: return 1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic add_noise_ping(int n);
    for (int i = 0; i < n; i++) add_beam(noise_value(), noise_value(), i == n - 1);
  endtask

  initial begin : stimulus
    int pos;
    int pings;
    // one beam, on nadir with a sounding
    add_beam(32767, 0, 1'b1);
    // one beam only: no spread, nothing found
    add_beam(-32768, -32768, 1'b1);
    // empty nadir beam between port and starboard
    add_beam(-1, -32768, 1'b0);
    add_beam(0, 0, 1'b0);
    add_beam(1, 32767, 1'b1);
    // crossing between two beams
    add_beam(1200, -300, 1'b0);
    add_beam(1210, -100, 1'b0);
    add_beam(1190, 50, 1'b0);
    add_beam(1180, 200, 1'b1);
    // one side only: spread of min and max
    add_beam(500, 10, 1'b0);
    add_beam(510, 20, 1'b0);
    add_beam(520, 30, 1'b1);
    // ties keep the first beam
    add_beam(700, 5, 1'b0);
    add_beam(710, 5, 1'b0);
    add_beam(-720, -5, 1'b0);
    add_beam(730, -5, 1'b1);
    // extremes in both directions
    add_beam(-32768, 32767, 1'b0);
    add_beam(32767, -32768, 1'b1);
    add_beam(0, 0, 1'b0);
    add_beam(0, 0, 1'b1);

    pings = 0;
    while (beam_queue.size() < BEAM_TARGET) begin
      pos = beam_queue.size();
      case ($urandom_range(0, 19))
        0, 1, 2: add_noise_ping($urandom_range(1, 20));
        3, 4:    add_swath_ping($urandom_range(17, 24));
        5:       add_swath_ping($urandom_range(1, 5));
        default: add_swath_ping($urandom_range(6, 16));
      endcase
      // the sender waits for the block to drain before these pings
      if (pings == 0 || pings == 12) beam_queue[pos].drain = 1'b1;
      pings++;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (beam_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (slot_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // beam driver
  always @(negedge clk_i) begin : driver
    raw_beam_t b;
    if (rst_ni && (!in_valid_i || beam_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (beam_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (beam_queue[0].drain && slot_expect.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (beam_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_valid_i <= 1'b0;
      end else begin
        b = beam_queue.pop_front();
        beam_depth_i <= b.depth;
        beam_distance_i <= b.distance;
        last_beam_i <= b.last;
        in_valid_i <= 1'b1;
      end
    end
  end

  // slot receiver backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (beam_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: predicts on each beam transfer, checks each slot transfer
  always @(posedge clk_i) begin : monitor
    slot_t want;
    logic beam_xfer;
    logic slot_xfer;
    beam_xfer = rst_ni && in_valid_i && !in_stall_o;
    slot_xfer = rst_ni && out_valid_o && !out_stall_i;
    beam_taken <= beam_xfer;
    if (beam_xfer) take_beam(beam_depth_i, beam_distance_i, last_beam_i);
    if (slot_xfer) begin
      if (slot_expect.size() == 0) begin
        $error("unexpected slot transfer: slot_index %0d", slot_index_o);
        errors++;
      end else begin
        want = slot_expect.pop_front();
        if (slot_index_o !== want.num) begin
          $error("slot_index expected %0d actual %0d", want.num, slot_index_o);
          errors++;
        end
        if (slot_depth_o !== want.depth) begin
          $error("slot_depth expected %0d actual %0d", want.depth, $signed(slot_depth_o));
          errors++;
        end
        if (slot_distance_o !== want.distance) begin
          $error("slot_distance expected %0d actual %0d", want.distance,
                 $signed(slot_distance_o));
          errors++;
        end
        if (center_found_o !== want.found) begin
          $error("center_found expected %0d actual %0d", want.found, center_found_o);
          errors++;
        end
        if (last_slot_o !== want.last) begin
          $error("last_slot expected %0d actual %0d", want.last, last_slot_o);
          errors++;
        end
      end
    end
    if (rst_ni) begin
      stuck_cycles = (beam_xfer || slot_xfer) ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/sbca_pkg.sv
rtl/sbca_mem.sv
rtl/sbca_div.sv
rtl/sonar_beam_center_align_top.sv
bench/testbench.sv
